FILE: hw/rtl/sme_pkg.sv
// Shared types, constants and arithmetic helpers for the screw motion exponential core.
package sme_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ARC_COUNT    = 30;
   localparam int NUM_STAGES   = CORDIC_STEPS + 7;

   typedef logic signed [71:0] wide_type;
   typedef logic signed [35:0] ang_type;
   typedef logic signed [31:0] word_type;

   localparam ang_type GAIN_INV_Q30 = 36'sd652032874;
   localparam ang_type ONE_Q30      = 36'sd1073741824;
   localparam ang_type PI_Q30       = 36'sd3373259426;
   localparam ang_type HALF_PI_Q30  = 36'sd1686629713;
   localparam ang_type TWO_PI_Q30   = 36'sd6746518852;
   localparam word_type ONE_Q28     = 32'sd268435456;
   localparam logic [28:0] LIMIT_RESET = 29'd268;

   typedef struct packed {
      word_type [2:0] w;
      word_type [2:0] v;
      word_type       th;
      logic [57:0]    lim_sq;
      logic [63:0]    nrm;
      logic           zero;
      wide_type [5:0] pw;
      wide_type [2:0] pv;
      word_type [5:0] m;
      word_type [2:0] pz;
      ang_type        x;
      ang_type        y;
      ang_type        z;
      logic           flip;
      ang_type        s;
      ang_type        omc;
      word_type       tms;
      wide_type [2:0] ps;
      wide_type [2:0] po;
      wide_type [5:0] pm;
      wide_type [5:0] pt;
      word_type [8:0] r;
      word_type [8:0] g;
      wide_type [8:0] gv;
      word_type [2:0] p;
   } pipe_type;

   // Arctangent of 2^-i in Q30, truncated.
   function automatic ang_type arc(input int unsigned i);
      case (i)
         0:  return 36'h03243F6A8;
         1:  return 36'h01DAC6705;
         2:  return 36'h00FADBAFC;
         3:  return 36'h007F56EA6;
         4:  return 36'h003FEAB76;
         5:  return 36'h001FFD55B;
         6:  return 36'h000FFFAAA;
         7:  return 36'h0007FFF55;
         8:  return 36'h0003FFFEA;
         9:  return 36'h0001FFFFD;
         10: return 36'h0000FFFFF;
         11: return 36'h00007FFFF;
         12: return 36'h00003FFFF;
         13: return 36'h00001FFFF;
         14: return 36'h00000FFFF;
         15: return 36'h000007FFF;
         16: return 36'h000003FFF;
         17: return 36'h000001FFF;
         18: return 36'h000000FFF;
         19: return 36'h0000007FF;
         20: return 36'h0000003FF;
         21: return 36'h0000001FF;
         22: return 36'h0000000FF;
         23: return 36'h00000007F;
         24: return 36'h00000003F;
         25: return 36'h00000001F;
         26: return 36'h00000000F;
         27: return 36'h000000007;
         28: return 36'h000000003;
         29: return 36'h000000001;
         default: return 36'h000000000;
      endcase
   endfunction

   // Round half up, then shift arithmetically.
   function automatic wide_type rnd(input wide_type v, input int unsigned n);
      return (v + (wide_type'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic word_type sat32(input wide_type v);
      if (v > wide_type'(64'sd2147483647)) return 32'sh7FFFFFFF;
      if (v < wide_type'(-64'sd2147483648)) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Index of entry (i, j) of the symmetric matrix in its six stored entries.
   function automatic int unsigned msel(input int unsigned i, input int unsigned j);
      case (i * 3 + j)
         0:    return 0;
         1, 3: return 1;
         2, 6: return 2;
         4:    return 3;
         5, 7: return 4;
         8:    return 5;
         default: return 0;
      endcase
   endfunction

   // Skew matrix entry (i, j) built from the products of a scalar with w.
   function automatic wide_type kterm(input wide_type [2:0] q, input int unsigned i,
                                      input int unsigned j);
      case (i * 3 + j)
         1: return -q[2];
         2: return q[1];
         3: return q[2];
         5: return -q[0];
         6: return -q[1];
         7: return q[0];
         default: return '0;
      endcase
   endfunction

endpackage

FILE: hw/rtl/screw_motion_exponential_core.sv
// Pipelined exponential of a screw axis: rotation and saturated translation.
//
//   channel  | ports                          | transfer
//   ---------+--------------------------------+---------------------------
//   request  | req_valid/req_ready, w v angle | one beat per screw motion
//   response | rsp_valid/rsp_ready, rot pos   | one beat per request beat
//   csr      | csr_wr_en, csr_wr_data         | write of zero_axis_limit
//
// The pipeline is CORDIC_STEPS + 7 stages deep and takes one beat per cycle
// unless stalled; each CORDIC stage holds one step of the sine and cosine.
// Reset clears all stage valid bits and loads the zero axis limit with 268.
// Each stage holds its beat while the stage after it is full and stalled, so a
// stall on the response side fills bubbles first and then backs up to req_ready.
module screw_motion_exponential_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_w_x,
   input  logic signed [31:0] req_w_y,
   input  logic signed [31:0] req_w_z,
   input  logic signed [31:0] req_v_x,
   input  logic signed [31:0] req_v_y,
   input  logic signed [31:0] req_v_z,
   input  logic signed [31:0] req_angle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_rot_00,
   output logic signed [31:0] rsp_rot_01,
   output logic signed [31:0] rsp_rot_02,
   output logic signed [31:0] rsp_rot_10,
   output logic signed [31:0] rsp_rot_11,
   output logic signed [31:0] rsp_rot_12,
   output logic signed [31:0] rsp_rot_20,
   output logic signed [31:0] rsp_rot_21,
   output logic signed [31:0] rsp_rot_22,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   input  logic        csr_wr_en,
   input  logic [28:0] csr_wr_data
);

   localparam int NS = sme_pkg::NUM_STAGES;
   localparam int CS = sme_pkg::CORDIC_STEPS;

   logic [28:0]       limit_ff;
   logic              vld_ff [NS];
   logic [NS:0]       rdy;
   sme_pkg::pipe_type pipe_ff [NS];
   sme_pkg::pipe_type pipe_in [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sme_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign rdy[NS]   = rsp_ready;
   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NS-1];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         assign rdy[k] = !vld_ff[k] || rdy[k+1];

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               pipe_ff[k] <= pipe_in[k];
            end
         end

         if (k == 0) begin : g_in
            // Products of the axis, angle scaling and range reduction.
            always_comb begin
               sme_pkg::ang_type z;
               pipe_in[k]       = '0;
               pipe_in[k].w[0]  = req_w_x;
               pipe_in[k].w[1]  = req_w_y;
               pipe_in[k].w[2]  = req_w_z;
               pipe_in[k].v[0]  = req_v_x;
               pipe_in[k].v[1]  = req_v_y;
               pipe_in[k].v[2]  = req_v_z;
               pipe_in[k].th    = req_angle;
               pipe_in[k].lim_sq = 58'(limit_ff) * 58'(limit_ff);
               for (int i = 0; i < 3; i++) begin
                  for (int j = i; j < 3; j++) begin
                     pipe_in[k].pw[sme_pkg::msel(i, j)] =
                        sme_pkg::wide_type'(pipe_in[k].w[i]) *
                        sme_pkg::wide_type'(pipe_in[k].w[j]);
                  end
                  pipe_in[k].pv[i] = sme_pkg::wide_type'(pipe_in[k].v[i]) *
                                     sme_pkg::wide_type'(req_angle);
               end
               z = sme_pkg::ang_type'(req_angle) <<< 2;
               if (z > sme_pkg::PI_Q30) z = z - sme_pkg::TWO_PI_Q30;
               if (z < -sme_pkg::PI_Q30) z = z + sme_pkg::TWO_PI_Q30;
               if (z > sme_pkg::HALF_PI_Q30) begin
                  z = z - sme_pkg::PI_Q30;
                  pipe_in[k].flip = 1'b1;
               end else if (z < -sme_pkg::HALF_PI_Q30) begin
                  z = z + sme_pkg::PI_Q30;
                  pipe_in[k].flip = 1'b1;
               end
               pipe_in[k].z = z;
               pipe_in[k].x = sme_pkg::GAIN_INV_Q30;
               pipe_in[k].y = '0;
            end
         end else if (k == 1) begin : g_prep
            // Zero axis test, the squared skew matrix and the pure translation.
            always_comb begin
               sme_pkg::wide_type o [6];
               sme_pkg::wide_type tr;
               pipe_in[k] = pipe_ff[k-1];
               pipe_in[k].nrm = 64'(pipe_ff[k-1].pw[0]) + 64'(pipe_ff[k-1].pw[3]) +
                                64'(pipe_ff[k-1].pw[5]);
               pipe_in[k].zero = pipe_in[k].nrm < 64'(pipe_ff[k-1].lim_sq);
               for (int m = 0; m < 6; m++) begin
                  o[m] = sme_pkg::rnd(pipe_ff[k-1].pw[m], 28);
               end
               tr = o[0] + o[3] + o[5];
               pipe_in[k].m[0] = sme_pkg::sat32(o[0] - tr);
               pipe_in[k].m[1] = sme_pkg::sat32(o[1]);
               pipe_in[k].m[2] = sme_pkg::sat32(o[2]);
               pipe_in[k].m[3] = sme_pkg::sat32(o[3] - tr);
               pipe_in[k].m[4] = sme_pkg::sat32(o[4]);
               pipe_in[k].m[5] = sme_pkg::sat32(o[5] - tr);
               for (int i = 0; i < 3; i++) begin
                  pipe_in[k].pz[i] = sme_pkg::sat32(sme_pkg::rnd(pipe_ff[k-1].pv[i], 28));
               end
            end
         end else if (k < CS + 2) begin : g_cordic
            // One rotation step toward zero residual angle.
            always_comb begin
               sme_pkg::ang_type xs;
               sme_pkg::ang_type ys;
               pipe_in[k] = pipe_ff[k-1];
               xs = pipe_ff[k-1].x >>> (k - 2);
               ys = pipe_ff[k-1].y >>> (k - 2);
               if (!pipe_ff[k-1].z[35]) begin
                  pipe_in[k].x = pipe_ff[k-1].x - ys;
                  pipe_in[k].y = pipe_ff[k-1].y + xs;
                  pipe_in[k].z = pipe_ff[k-1].z - sme_pkg::arc(k - 2);
               end else begin
                  pipe_in[k].x = pipe_ff[k-1].x + ys;
                  pipe_in[k].y = pipe_ff[k-1].y - xs;
                  pipe_in[k].z = pipe_ff[k-1].z + sme_pkg::arc(k - 2);
               end
            end
         end else if (k == CS + 2) begin : g_trig
            always_comb begin
               sme_pkg::ang_type c;
               pipe_in[k] = pipe_ff[k-1];
               pipe_in[k].s = pipe_ff[k-1].flip ? -pipe_ff[k-1].y : pipe_ff[k-1].y;
               c = pipe_ff[k-1].flip ? -pipe_ff[k-1].x : pipe_ff[k-1].x;
               pipe_in[k].omc = sme_pkg::ONE_Q30 - c;
               pipe_in[k].tms = sme_pkg::sat32(sme_pkg::wide_type'(pipe_ff[k-1].th) -
                                  sme_pkg::rnd(sme_pkg::wide_type'(pipe_in[k].s), 2));
            end
         end else if (k == CS + 3) begin : g_mul
            always_comb begin
               pipe_in[k] = pipe_ff[k-1];
               for (int i = 0; i < 3; i++) begin
                  pipe_in[k].ps[i] = sme_pkg::wide_type'(pipe_ff[k-1].s) *
                                     sme_pkg::wide_type'(pipe_ff[k-1].w[i]);
                  pipe_in[k].po[i] = sme_pkg::wide_type'(pipe_ff[k-1].omc) *
                                     sme_pkg::wide_type'(pipe_ff[k-1].w[i]);
               end
               for (int m = 0; m < 6; m++) begin
                  pipe_in[k].pm[m] = sme_pkg::wide_type'(pipe_ff[k-1].omc) *
                                     sme_pkg::wide_type'(pipe_ff[k-1].m[m]);
                  pipe_in[k].pt[m] = sme_pkg::wide_type'(pipe_ff[k-1].tms) *
                                     sme_pkg::wide_type'(pipe_ff[k-1].m[m]);
               end
            end
         end else if (k == CS + 4) begin : g_sum
            // Rotation entries and the translation gain matrix.
            always_comb begin
               sme_pkg::wide_type di;
               sme_pkg::wide_type dg;
               pipe_in[k] = pipe_ff[k-1];
               for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) begin
                     di = (i == j) ? sme_pkg::wide_type'(sme_pkg::ONE_Q28) : '0;
                     dg = (i == j) ? sme_pkg::wide_type'(pipe_ff[k-1].th) : '0;
                     pipe_in[k].r[i*3+j] = sme_pkg::sat32(di +
                        sme_pkg::rnd(sme_pkg::kterm(pipe_ff[k-1].ps, i, j), 30) +
                        sme_pkg::rnd(pipe_ff[k-1].pm[sme_pkg::msel(i, j)], 30));
                     pipe_in[k].g[i*3+j] = sme_pkg::sat32(dg +
                        sme_pkg::rnd(sme_pkg::kterm(pipe_ff[k-1].po, i, j), 30) +
                        sme_pkg::rnd(pipe_ff[k-1].pt[sme_pkg::msel(i, j)], 28));
                  end
               end
            end
         end else if (k == CS + 5) begin : g_gv
            always_comb begin
               pipe_in[k] = pipe_ff[k-1];
               for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) begin
                     pipe_in[k].gv[i*3+j] = sme_pkg::wide_type'(pipe_ff[k-1].g[i*3+j]) *
                                            sme_pkg::wide_type'(pipe_ff[k-1].v[j]);
                  end
               end
            end
         end else begin : g_out
            // Translation sums and the pure translation override of pos and rot.
            always_comb begin
               pipe_in[k] = pipe_ff[k-1];
               for (int i = 0; i < 3; i++) begin
                  if (pipe_ff[k-1].zero) begin
                     pipe_in[k].p[i] = pipe_ff[k-1].pz[i];
                  end else begin
                     pipe_in[k].p[i] = sme_pkg::sat32(
                        sme_pkg::rnd(pipe_ff[k-1].gv[i*3], 28) +
                        sme_pkg::rnd(pipe_ff[k-1].gv[i*3+1], 28) +
                        sme_pkg::rnd(pipe_ff[k-1].gv[i*3+2], 28));
                  end
                  for (int j = 0; j < 3; j++) begin
                     if (pipe_ff[k-1].zero) begin
                        pipe_in[k].r[i*3+j] = (i == j) ? sme_pkg::ONE_Q28 : '0;
                     end
                  end
               end
            end
         end
      end
   endgenerate

   assign rsp_rot_00 = pipe_ff[NS-1].r[0];
   assign rsp_rot_01 = pipe_ff[NS-1].r[1];
   assign rsp_rot_02 = pipe_ff[NS-1].r[2];
   assign rsp_rot_10 = pipe_ff[NS-1].r[3];
   assign rsp_rot_11 = pipe_ff[NS-1].r[4];
   assign rsp_rot_12 = pipe_ff[NS-1].r[5];
   assign rsp_rot_20 = pipe_ff[NS-1].r[6];
   assign rsp_rot_21 = pipe_ff[NS-1].r[7];
   assign rsp_rot_22 = pipe_ff[NS-1].r[8];
   assign rsp_pos_x  = pipe_ff[NS-1].p[0];
   assign rsp_pos_y  = pipe_ff[NS-1].p[1];
   assign rsp_pos_z  = pipe_ff[NS-1].p[2];

endmodule
